### rtl/vcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcr_pkg
// Shared sizes, register indexes and interface structs of the visit count
// rank extractor.
// ----------------------------------------------------------------------------
package vcr_pkg;

	localparam int MAX_ROWS   = 32;
	localparam int MAX_COLS   = 32;
	localparam int COUNT_BITS = 16;

	localparam int ROW_BITS     = $clog2(MAX_ROWS);
	localparam int COL_BITS     = $clog2(MAX_COLS);
	localparam int ROW_CNT_BITS = $clog2(MAX_ROWS + 1);
	localparam int COL_CNT_BITS = $clog2(MAX_COLS + 1);
	localparam int ADDR_BITS    = ROW_BITS + COL_BITS;
	localparam int RAM_DEPTH    = 1 << ADDR_BITS;

	localparam int CFG_BITS   = 6;
	localparam int FIELD_RC   = 5;
	localparam int FIELD_CNT  = 16;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// configuration register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// command codes
	localparam logic CMD_VISIT   = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	typedef struct packed {
		logic [ROW_CNT_BITS-1:0] nr;
		logic [COL_CNT_BITS-1:0] nc;
	} area_t;

	typedef struct packed {
		logic                command;
		logic [FIELD_RC-1:0] row;
		logic [FIELD_RC-1:0] col;
	} cmd_t;

	typedef struct packed {
		logic                 found;
		logic [FIELD_RC-1:0]  top_row;
		logic [FIELD_RC-1:0]  top_col;
		logic [FIELD_CNT-1:0] top_count;
	} res_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_BITS-1:0]  waddr;
		logic [COUNT_BITS-1:0] wdata;
		logic [ADDR_BITS-1:0]  raddr;
	} ram_req_t;

endpackage
`default_nettype wire

### rtl/visit_count_rank_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// visit_count_rank_extractor
// Grid of saturating visit counters with ranked extraction of the top cell.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes all 1024 counter RAM entries, one per
// cycle; configuration writes are taken meanwhile, command beats are not.
// A visit reads the counter, then writes it back saturating; an extract reads
// one RAM cell per cell of the area, then drains the compare; an ignored visit
// or an extract over an empty area goes straight to the result. One command is
// in flight at a time: the next beat is taken once the result is registered.
// ----------------------------------------------------------------------------
module visit_count_rank_extractor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data,
	// command stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // row [4:0], col [9:5], zero [15:10]
	input  wire logic        s_tuser,  // command [0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // top_row [4:0], top_col [9:5],
	                                   // top_count [25:10], zero [31:26]
	output logic             m_tuser   // found [0]
);

	logic [vcr_pkg::CFG_BITS-1:0]   rows_q;
	logic [vcr_pkg::CFG_BITS-1:0]   cols_q;
	vcr_pkg::area_t                 area;
	vcr_pkg::cmd_t                  cmd;
	vcr_pkg::res_t                  res;
	vcr_pkg::res_t                  out_q;
	logic                           out_valid_q;
	logic                           res_valid;
	logic                           res_take;
	vcr_pkg::ram_req_t              ram_req;
	logic [vcr_pkg::COUNT_BITS-1:0] ram_rdata;

	// Configuration is always taken; the user must change it only when idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= vcr_pkg::CFG_BITS'(32);
			cols_q <= vcr_pkg::CFG_BITS'(32);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vcr_pkg::REG_ROWS: rows_q <= cfg_data;
				vcr_pkg::REG_COLS: cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Limit the area in use to the grid size.
	always_comb begin
		if (32'(rows_q) > vcr_pkg::MAX_ROWS) begin
			area.nr = vcr_pkg::ROW_CNT_BITS'(vcr_pkg::MAX_ROWS);
		end else begin
			area.nr = vcr_pkg::ROW_CNT_BITS'(rows_q);
		end
		if (32'(cols_q) > vcr_pkg::MAX_COLS) begin
			area.nc = vcr_pkg::COL_CNT_BITS'(vcr_pkg::MAX_COLS);
		end else begin
			area.nc = vcr_pkg::COL_CNT_BITS'(cols_q);
		end
	end

	// Unpack the command beat.
	always_comb begin
		cmd.command = s_tuser;
		cmd.row     = s_tdata[4:0];
		cmd.col     = s_tdata[9:5];
	end

	vcr_ram #(
		.WIDTH (vcr_pkg::COUNT_BITS),
		.DEPTH (vcr_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	vcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.area      (area),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// Result register: load when empty or when the held beat leaves this cycle.
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.found;
	assign m_tdata  = {6'd0, out_q.top_count, out_q.top_col, out_q.top_row};

	// A beat without a found cell carries all zero fields.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
		else $error("result without found cell has nonzero fields");

	// A found cell lies inside the area in use and held a nonzero count.
	a_found_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((32'(m_tdata[4:0]) < 32'(area.nr))
			&& (32'(m_tdata[9:5]) < 32'(area.nc)) && (m_tdata[25:10] != 16'd0)))
		else $error("extracted cell outside area or with zero count");

	// One command at a time: the sequencer drops ready after each accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command accepted while another is in progress");

endmodule
`default_nettype wire

### rtl/vcr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vcr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/vcr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcr_ctrl
// Sequencer for clear pass, visit read-modify-write and extract scan, with
// the shared compare unit that tracks the running maximum.
// ----------------------------------------------------------------------------
module vcr_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire vcr_pkg::area_t                 area,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire vcr_pkg::cmd_t                  cmd,
	output logic                                res_valid,
	output vcr_pkg::res_t                       res,
	input  wire logic                           res_take,
	output vcr_pkg::ram_req_t                   ram_req,
	input  wire logic [vcr_pkg::COUNT_BITS-1:0] ram_rdata
);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_VRD   = 7'b0000100,
		ST_VWR   = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                          state_q;
	logic [vcr_pkg::ADDR_BITS-1:0]   clr_addr_q;
	logic [vcr_pkg::ADDR_BITS-1:0]   visit_addr_q;
	logic [vcr_pkg::ROW_BITS-1:0]    r_q;
	logic [vcr_pkg::COL_BITS-1:0]    c_q;
	logic                            scan_valid_s1;
	logic [vcr_pkg::ROW_BITS-1:0]    r_s1;
	logic [vcr_pkg::COL_BITS-1:0]    c_s1;
	logic                            hit_q;
	logic [vcr_pkg::COUNT_BITS-1:0]  best_q;
	logic [vcr_pkg::ROW_BITS-1:0]    br_q;
	logic [vcr_pkg::COL_BITS-1:0]    bc_q;
	logic                            in_area;
	logic                            last_col;
	logic                            last_row;
	logic                            better;
	logic [vcr_pkg::COUNT_BITS-1:0]  sat_inc;

	assign in_area = (32'(cmd.row) < 32'(area.nr)) && (32'(cmd.col) < 32'(area.nc));
	assign last_col = ((vcr_pkg::COL_CNT_BITS'(c_q) + 1'b1) == area.nc);
	assign last_row = ((vcr_pkg::ROW_CNT_BITS'(r_q) + 1'b1) == area.nr);
	assign better   = scan_valid_s1 && (ram_rdata > best_q);
	assign sat_inc  = (ram_rdata == vcr_pkg::COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.found     = hit_q;
		res.top_row   = vcr_pkg::FIELD_RC'(br_q);
		res.top_col   = vcr_pkg::FIELD_RC'(bc_q);
		res.top_count = vcr_pkg::FIELD_CNT'(best_q);
	end

	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = clr_addr_q;
		ram_req.wdata = '0;
		ram_req.raddr = {r_q, c_q};
		unique case (state_q)
			ST_CLEAR: begin
				ram_req.we = 1'b1;
			end
			ST_VRD: begin
				ram_req.raddr = visit_addr_q;
			end
			ST_VWR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = visit_addr_q;
				ram_req.wdata = sat_inc;
			end
			ST_DONE: begin
				// zero the extracted cell; rewriting zero while stalled is harmless
				ram_req.we    = hit_q;
				ram_req.waddr = {br_q, bc_q};
			end
			ST_IDLE, ST_SCAN, ST_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			scan_valid_s1 <= 1'b0;
			hit_q         <= 1'b0;
		end else begin
			scan_valid_s1 <= (state_q == ST_SCAN);
			if (better) begin
				hit_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						hit_q <= 1'b0;
						if (cmd.command == vcr_pkg::CMD_EXTRACT) begin
							if ((area.nr == '0) || (area.nc == '0)) begin
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_SCAN;
							end
						end else if (in_area) begin
							state_q <= ST_VRD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_VRD:   state_q <= ST_VWR;
				ST_VWR:   state_q <= ST_DONE;
				ST_SCAN: begin
					if (last_col && last_row) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		r_s1 <= r_q;
		c_s1 <= c_q;
		if (better) begin
			best_q <= ram_rdata;
			br_q   <= r_s1;
			bc_q   <= c_s1;
		end
		if (state_q == ST_IDLE) begin
			r_q          <= '0;
			c_q          <= '0;
			visit_addr_q <= {vcr_pkg::ROW_BITS'(cmd.row), vcr_pkg::COL_BITS'(cmd.col)};
			if (in_valid) begin
				best_q <= '0;
				br_q   <= '0;
				bc_q   <= '0;
			end
		end else if (state_q == ST_SCAN) begin
			if (last_col) begin
				c_q <= '0;
				r_q <= r_q + 1'b1;
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### verif/visit_count_rank_extractor_tb.sv
// ----------------------------------------------------------------------------
// visit_count_rank_extractor_tb
// Self-checking bench for the visit counter grid with ranked extraction.
// A short scripted sequence runs at the reset area size. Random phases follow
// over a range of area sizes, including zero, oversize and shrunk areas.
// Every command beat runs through a local copy of the counter grid. That copy
// predicts the result beat, which is compared field by field as it leaves
// the block.
// ----------------------------------------------------------------------------
module visit_count_rank_extractor_tb;

	localparam int LIMIT_CYCLES  = 3_000_000;
	localparam int HOLD_CYCLES   = 400;
	// one full-area extract plus margin: nothing may show up after the drain
	localparam int SETTLE_CYCLES = vcr_pkg::MAX_ROWS * vcr_pkg::MAX_COLS + 64;
	localparam int REPORT_MAX    = 10;
	localparam int PHASE_COUNT   = 14;
	localparam int SQUEEZE_PHASE = 8;
	localparam int SCRIPT_LEN    = 16;

	localparam vcr_pkg::res_t NO_HIT = '0;

	typedef struct {
		logic          cmd;
		logic [4:0]    r;
		logic [4:0]    c;
		bit            typed;
		vcr_pkg::res_t want;
	} probe_t;

	typedef struct {
		logic [vcr_pkg::CFG_BITS-1:0] rows;
		logic [vcr_pkg::CFG_BITS-1:0] cols;
		int                           items;
		int                           extract_pct;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [5:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // row [4:0], col [9:5], zero [15:10]
	logic        s_tuser;  // command [0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // top_row [4:0], top_col [9:5], top_count [25:10]
	logic        m_tuser;  // found [0]

	// local copy of the counter grid and of the area registers
	logic [vcr_pkg::COUNT_BITS-1:0] grid_counts [vcr_pkg::MAX_ROWS][vcr_pkg::MAX_COLS];
	logic [vcr_pkg::CFG_BITS-1:0]   area_rows;
	logic [vcr_pkg::CFG_BITS-1:0]   area_cols;

	vcr_pkg::res_t awaited_replies [$];
	int            fail_count;
	bit            quiet;          // no random idling on either side while set
	bit            sink_hold_req;  // ask the result side for one long hold-off
	probe_t        script [SCRIPT_LEN];
	phase_t        plan [PHASE_COUNT];

	always #5 clk = ~clk;

	visit_count_rank_extractor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Apply one command to the local grid and return the result it must give.
	// Oversize registers clamp to the grid; zero gives an empty area. Cells
	// outside the area keep their counts untouched.
	function automatic vcr_pkg::res_t tally_or_extract(logic cmd, logic [4:0] r,
			logic [4:0] c);
		int                             nr;
		int                             nc;
		int                             i;
		int                             j;
		vcr_pkg::res_t                  reply;
		logic [vcr_pkg::COUNT_BITS-1:0] best;
		nr = (area_rows > vcr_pkg::MAX_ROWS) ? vcr_pkg::MAX_ROWS : int'(area_rows);
		nc = (area_cols > vcr_pkg::MAX_COLS) ? vcr_pkg::MAX_COLS : int'(area_cols);
		reply = NO_HIT;
		if (cmd == vcr_pkg::CMD_VISIT) begin
			// saturate, and drop visits outside the area
			if (r < nr && c < nc && grid_counts[r][c] != vcr_pkg::COUNT_MAX)
				grid_counts[r][c] = grid_counts[r][c] + 1'b1;
			return reply;
		end
		// row-major scan with strict compare keeps the lowest row, then column
		best = '0;
		for (i = 0; i < nr; i++) begin
			for (j = 0; j < nc; j++) begin
				if (grid_counts[i][j] > best) begin
					best          = grid_counts[i][j];
					reply.found   = 1'b1;
					reply.top_row = 5'(i);
					reply.top_col = 5'(j);
				end
			end
		end
		if (reply.found) begin
			reply.top_count = vcr_pkg::FIELD_CNT'(best);
			grid_counts[reply.top_row][reply.top_col] = '0;
		end
		return reply;
	endfunction

	// Mostly no gap, sometimes a few cycles, rarely a long one.
	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Write both area registers back to back; hold valid across the pair.
	task automatic set_area(input logic [vcr_pkg::CFG_BITS-1:0] rows,
			input logic [vcr_pkg::CFG_BITS-1:0] cols);
		cfg_valid <= 1'b1;
		cfg_index <= vcr_pkg::REG_ROWS;
		cfg_data  <= rows;
		do @(posedge clk); while (!cfg_ready);
		area_rows = rows;
		cfg_index <= vcr_pkg::REG_COLS;
		cfg_data  <= cols;
		do @(posedge clk); while (!cfg_ready);
		area_cols = cols;
		cfg_valid <= 1'b0;
	endtask

	// Offer one command beat and book its result once the block takes it.
	task automatic send_command(input logic cmd, input logic [4:0] r, input logic [4:0] c,
			input bit typed, input vcr_pkg::res_t want);
		vcr_pkg::res_t predicted;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'b0, c, r};
		do @(posedge clk); while (!s_tready);
		predicted = tally_or_extract(cmd, r, c);
		awaited_replies.push_back(typed ? want : predicted);
	endtask

	// Drop valid for a random gap, or keep it up for a back-to-back beat.
	task automatic pause_sender();
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// Result side: check each accepted beat, then pick ready for the next cycle.
	initial begin : result_sink
		int            stall_left;
		vcr_pkg::res_t want;
		vcr_pkg::res_t got;
		stall_left = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.found     = m_tuser;
				got.top_row   = m_tdata[4:0];
				got.top_col   = m_tdata[9:5];
				got.top_count = m_tdata[25:10];
				if (awaited_replies.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected result beat: found=%0d row=%0d col=%0d count=%0d",
							got.found, got.top_row, got.top_col, got.top_count);
				end else begin
					want = awaited_replies.pop_front();
					if (got.found !== want.found || got.top_row !== want.top_row ||
							got.top_col !== want.top_col || got.top_count !== want.top_count) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("result mismatch: expected found=%0d row=%0d col=%0d count=%0d,",
								want.found, want.top_row, want.top_col, want.top_count,
								" got found=%0d row=%0d col=%0d count=%0d",
								got.found, got.top_row, got.top_col, got.top_count);
					end
				end
			end
			// a requested hold-off takes precedence over the random stalls
			if (stall_left == 0) begin
				if (sink_hold_req) begin
					sink_hold_req = 1'b0;
					stall_left    = HOLD_CYCLES;
				end else begin
					stall_left = pick_gap();
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int         p;
		int         k;
		int         done;
		int         nr;
		int         nc;
		logic       cmd;
		logic [4:0] r;
		logic [4:0] c;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= vcr_pkg::REG_ROWS;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tuser   <= vcr_pkg::CMD_VISIT;
		s_tdata   <= '0;
		area_rows  = 6'd32;
		area_cols  = 6'd32;
		foreach (grid_counts[i, j])
			grid_counts[i][j] = '0;
		fail_count    = 0;
		quiet         = 1'b0;
		sink_hold_req = 1'b0;

		// Scripted part at the reset area of 32 by 32. Visits and the empty
		// extracts have obvious results; the tie-break order is left to the
		// local grid.
		script = '{
			'{vcr_pkg::CMD_EXTRACT, 5'd0,  5'd0,  1'b1, NO_HIT},  // nothing counted yet
			'{vcr_pkg::CMD_VISIT,   5'd0,  5'd0,  1'b1, NO_HIT},
			'{vcr_pkg::CMD_VISIT,   5'd31, 5'd31, 1'b1, NO_HIT},
			'{vcr_pkg::CMD_VISIT,   5'd31, 5'd31, 1'b1, NO_HIT},
			'{vcr_pkg::CMD_VISIT,   5'd0,  5'd0,  1'b1, NO_HIT},
			'{vcr_pkg::CMD_VISIT,   5'd0,  5'd31, 1'b1, NO_HIT},
			'{vcr_pkg::CMD_VISIT,   5'd31, 5'd0,  1'b1, NO_HIT},
			'{vcr_pkg::CMD_VISIT,   5'd10, 5'd21, 1'b1, NO_HIT},
			'{vcr_pkg::CMD_VISIT,   5'd21, 5'd10, 1'b1, NO_HIT},
			// two cells at count 2: the lower row wins, then the other one
			'{vcr_pkg::CMD_EXTRACT, 5'd31, 5'd31, 1'b0, NO_HIT},
			'{vcr_pkg::CMD_EXTRACT, 5'd17, 5'd3,  1'b0, NO_HIT},
			'{vcr_pkg::CMD_EXTRACT, 5'd0,  5'd0,  1'b0, NO_HIT},
			'{vcr_pkg::CMD_EXTRACT, 5'd21, 5'd10, 1'b0, NO_HIT},
			'{vcr_pkg::CMD_EXTRACT, 5'd10, 5'd21, 1'b0, NO_HIT},
			'{vcr_pkg::CMD_EXTRACT, 5'd0,  5'd0,  1'b0, NO_HIT},
			'{vcr_pkg::CMD_EXTRACT, 5'd31, 5'd0,  1'b1, NO_HIT}   // grid drained again
		};

		// Area settings: zero on either axis, oversize clamping to the grid,
		// single cell, thin strips, and a full-size area late on so that
		// counts left outside smaller areas come back into the scan.
		plan = '{
			'{6'd0,  6'd32, 8,  50},
			'{6'd32, 6'd0,  8,  50},
			'{6'd63, 6'd63, 24, 10},
			'{6'd1,  6'd1,  20, 30},
			'{6'd4,  6'd4,  40, 25},
			'{6'd2,  6'd7,  40, 25},
			'{6'd7,  6'd2,  40, 25},
			'{6'd3,  6'd5,  40, 30},
			'{6'd8,  6'd8,  50, 20},
			'{6'd33, 6'd1,  20, 25},
			'{6'd1,  6'd40, 20, 25},
			'{6'd5,  6'd3,  40, 30},
			'{6'd32, 6'd32, 20, 10},
			'{6'd6,  6'd6,  40, 25}
		};

		// reset held, then released once and never again
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its RAM after reset; the first beat waits on tready.
		for (k = 0; k < SCRIPT_LEN; k++) begin
			send_command(script[k].cmd, script[k].r, script[k].c, script[k].typed,
				script[k].want);
			pause_sender();
		end
		s_tvalid <= 1'b0;
		wait_drained();

		for (p = 0; p < PHASE_COUNT; p++) begin
			// reconfigure only with nothing outstanding
			set_area(plan[p].rows, plan[p].cols);
			quiet = ($urandom_range(0, 3) == 0);
			if (p == SQUEEZE_PHASE) begin
				// keep offering beats while the result side holds off
				quiet         = 1'b1;
				sink_hold_req = 1'b1;
			end
			nr = (plan[p].rows > vcr_pkg::MAX_ROWS) ? vcr_pkg::MAX_ROWS : int'(plan[p].rows);
			nc = (plan[p].cols > vcr_pkg::MAX_COLS) ? vcr_pkg::MAX_COLS : int'(plan[p].cols);
			done = 0;
			while (done < plan[p].items) begin
				if ($urandom_range(0, 99) < plan[p].extract_pct) begin
					cmd = vcr_pkg::CMD_EXTRACT;
					r   = 5'($urandom);
					c   = 5'($urandom);
					done++;
				end else if (nr == 0 || nc == 0 || $urandom_range(0, 9) == 0) begin
					// stray visit anywhere in the field range; may fall outside
					cmd = vcr_pkg::CMD_VISIT;
					r   = 5'($urandom);
					c   = 5'($urandom);
					if (r < nr && c < nc)
						done++;
				end else begin
					cmd = vcr_pkg::CMD_VISIT;
					r   = 5'($urandom_range(0, nr - 1));
					c   = 5'($urandom_range(0, nc - 1));
					done++;
				end
				send_command(cmd, r, c, 1'b0, NO_HIT);
				pause_sender();
			end
			s_tvalid <= 1'b0;
			wait_drained();
			quiet = 1'b0;
		end

		// let any stray beat surface before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_CYCLES * 10);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
